/* rtl/core/fcds_pkg.sv */
// shared types and codes for the fractional clock divider search
package fcds_pkg;

	localparam logic [1:0] ST_EXACT_INT  = 2'd0;
	localparam logic [1:0] ST_CARRIED    = 2'd1;
	localparam logic [1:0] ST_EXACT_FRAC = 2'd2;
	localparam logic [1:0] ST_BEST       = 2'd3;

	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(31);
	localparam logic [CNT_W-1:0] QUO_LAST_STEP = CNT_W'(7);

	typedef struct packed {
		logic [31:0] base_clock;
		logic [31:0] target_freq;
	} req_t;

	typedef struct packed {
		logic [31:0] integer_divider;
		logic [7:0]  frac_denominator;
		logic [7:0]  frac_numerator;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [2:0] {
		SEL_SAT,
		SEL_EXACT_INT,
		SEL_CARRIED,
		SEL_EXACT_FRAC,
		SEL_BEST
	} res_sel_t;

	typedef struct packed {
		logic     load_req;
		logic     div_step;
		logic     srch_init;
		logic     quo_step;
		logic     eval;
		logic     next_den;
		logic     load_rsp;
		res_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic tgt_zero;
		logic rem_zero;
		logic carry;
		logic exact;
		logic den_last;
	} dp_stat_t;

endpackage

/* rtl/core/fcds_ctrl.sv */
// sequencer for the divider search: long division, checks, denominator loop
module fcds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  fcds_pkg::dp_stat_t stat,
	output fcds_pkg::dp_cmd_t  cmd
);
	import fcds_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_CHECK,
		S_QUO,
		S_EVAL,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	res_sel_t         sel_q;
	logic             rsp_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.sel       = sel_q;
		cmd.load_req  = (state_q == S_IDLE) && req_valid;
		cmd.div_step  = (state_q == S_DIV);
		cmd.srch_init = (state_q == S_CHECK) && !stat.tgt_zero && !stat.rem_zero &&
			!stat.carry;
		cmd.quo_step  = (state_q == S_QUO);
		cmd.eval      = (state_q == S_EVAL);
		cmd.next_den  = (state_q == S_EVAL) && !stat.exact && !stat.den_last;
		cmd.load_rsp  = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sel_q       <= SEL_SAT;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_rsp)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cnt_q   <= DIV_LAST_STEP;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (stat.tgt_zero) begin
						sel_q   <= SEL_SAT;
						state_q <= S_FINISH;
					end else if (stat.rem_zero) begin
						sel_q   <= SEL_EXACT_INT;
						state_q <= S_FINISH;
					end else if (stat.carry) begin
						sel_q   <= SEL_CARRIED;
						state_q <= S_FINISH;
					end else begin
						cnt_q   <= QUO_LAST_STEP;
						state_q <= S_QUO;
					end
				end
				S_QUO: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (stat.exact) begin
						sel_q   <= SEL_EXACT_FRAC;
						state_q <= S_FINISH;
					end else if (stat.den_last) begin
						sel_q   <= SEL_BEST;
						state_q <= S_FINISH;
					end else begin
						cnt_q   <= QUO_LAST_STEP;
						state_q <= S_QUO;
					end
				end
				S_FINISH: begin
					if (!rsp_valid_q || !rsp_stall)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_FINISH)
		else $error("result beat raised outside finish");

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req_valid) |=> (state_q == S_DIV && cnt_q == DIV_LAST_STEP))
		else $error("accepted beat did not start the division");

	a_eval_after_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> ($past(state_q) == S_QUO && $past(cnt_q) == '0))
		else $error("candidate evaluated without a full quotient");

endmodule

/* rtl/core/fcds_dp.sv */
// datapath: restoring divider, carry test, rounded quotient per denominator, best tracking
module fcds_dp #(
	parameter int MAX_DENOM = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fcds_pkg::req_t     req,
	input  fcds_pkg::dp_cmd_t  cmd,
	output fcds_pkg::dp_stat_t stat,
	output fcds_pkg::rsp_t     rsp
);
	import fcds_pkg::*;

	logic [31:0] tgt_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [39:0] ma_q;
	logic [41:0] frem_q;
	logic [39:0] dv_q;
	logic [7:0]  a_q;
	logic [7:0]  b_q;
	logic [7:0]  best_a_q;
	logic [7:0]  best_b_q;
	logic [31:0] best_err_q;
	logic        have_q;
	rsp_t        rsp_q;

	logic [32:0] div_trial;
	logic        div_ge;
	logic [38:0] r126;
	logic [38:0] t125;
	logic        quo_ge;
	logic [32:0] diff;
	logic [32:0] diff_abs;
	logic [31:0] err;
	logic        exact;
	logic [39:0] ma_new;

	function automatic logic [38:0] r_ext7(input logic [31:0] v);
		r_ext7 = {v, 7'b0};
	endfunction

	// one bit of n = base / target per cycle
	assign div_trial = {rem_q, quo_q[31]};
	assign div_ge    = div_trial >= {1'b0, tgt_q};

	assign r126 = {r_ext7(rem_q)} - {6'b0, rem_q, 1'b0};
	assign t125 = {r_ext7(tgt_q)} - {5'b0, tgt_q, 2'b0} + {7'b0, tgt_q};

	assign quo_ge = frem_q >= {2'b0, dv_q};

	// frem = 2*ma + tgt - 2*tgt*b, so tgt*b - ma = (tgt - frem) / 2, always even
	assign diff     = {1'b0, tgt_q} - frem_q[32:0];
	assign diff_abs = diff[32] ? (33'd0 - diff) : diff;
	assign err      = diff_abs[32:1];
	assign exact    = (frem_q[32:0] == {1'b0, tgt_q});

	assign ma_new = cmd.srch_init ? {7'b0, rem_q, 1'b0} : (ma_q + {8'b0, rem_q});

	assign stat.tgt_zero = (tgt_q == '0);
	assign stat.rem_zero = (rem_q == '0);
	assign stat.carry    = r126 > t125;
	assign stat.exact    = exact;
	assign stat.den_last = (a_q == 8'(MAX_DENOM));

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			tgt_q <= req.target_freq;
			quo_q <= req.base_clock;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[30:0], div_ge};
			rem_q <= div_ge ? 32'(div_trial - {1'b0, tgt_q}) : div_trial[31:0];
		end

		if (cmd.srch_init || cmd.next_den) begin
			ma_q   <= ma_new;
			a_q    <= cmd.srch_init ? 8'd2 : a_q + 8'd1;
			frem_q <= {1'b0, ma_new, 1'b0} + {10'b0, tgt_q};
			dv_q   <= {tgt_q, 8'b0};
			b_q    <= '0;
		end else if (cmd.quo_step) begin
			if (quo_ge)
				frem_q <= frem_q - {2'b0, dv_q};
			b_q  <= {b_q[6:0], quo_ge};
			dv_q <= {1'b0, dv_q[39:1]};
		end

		if (cmd.eval && (!have_q || err < best_err_q)) begin
			best_err_q <= err;
			best_a_q   <= a_q;
			best_b_q   <= b_q;
		end

		if (cmd.load_rsp) begin
			case (cmd.sel)
				SEL_SAT:        rsp_q <= '{32'hFFFF_FFFF, 8'd1, 8'd0, ST_EXACT_INT};
				SEL_EXACT_INT:  rsp_q <= '{quo_q, 8'd1, 8'd0, ST_EXACT_INT};
				SEL_CARRIED:    rsp_q <= '{quo_q + 32'd1, 8'd1, 8'd0, ST_CARRIED};
				SEL_EXACT_FRAC: rsp_q <= '{quo_q, a_q, b_q, ST_EXACT_FRAC};
				SEL_BEST:       rsp_q <= '{quo_q, best_a_q, best_b_q, ST_BEST};
				default:        rsp_q <= '{quo_q, best_a_q, best_b_q, ST_BEST};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			have_q <= 1'b0;
		else if (cmd.srch_init)
			have_q <= 1'b0;
		else if (cmd.eval)
			have_q <= 1'b1;
	end

	assign rsp = rsp_q;

	a_num_le_den: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> (b_q <= a_q))
		else $error("fraction numerator above denominator");

	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> (frem_q < {9'b0, tgt_q, 1'b0}))
		else $error("rounded quotient remainder out of range");

endmodule

/* rtl/core/fractional_clock_divider_search.sv */
// top level of the fractional clock divider search
//
// req channel: one beat carries base_clock and target_freq. The block answers
// each beat with exactly one beat on the rsp channel: integer divider N, the
// fraction b/a (1 and 0 when unused) and a two-bit status (exact integer,
// carried up, exact fraction, best approximation).
// An item passes through the restoring divider for N and the remainder, then
// the zero and carry tests, then, for each denominator tried from 2 up to
// MAX_DENOM, the 8 quotient bits of the rounded division and one compare,
// and last the load of the result register. A new request is taken once
// the previous one has left the search, one item at a time.
// The result register sits between the search and the rsp port, so a new
// request is accepted while a result still waits; a stalled rsp beat holds,
// and a finished search then waits in its last state until the register frees.
// Reset empties the block: no result pending, ready for a request. No
// clearing pass is needed.
module fractional_clock_divider_search #(
	parameter int MAX_DENOM = 63
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fcds_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fcds_pkg::rsp_t rsp
);
	import fcds_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fcds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fcds_dp #(
		.MAX_DENOM (MAX_DENOM)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
